// ===== rtl/cddm_pkg.sv =====
package cddm_pkg;

   localparam int SECTORS_PER_TRACK    = 40;
   localparam int SEEK_TRACKS_PER_TICK = 51;
   localparam int SEG_COUNT            = 2 * SECTORS_PER_TRACK;
   localparam int SEG_START            = 12 % SEG_COUNT;
   localparam int SEEK_HALF_RAW        = SEEK_TRACKS_PER_TICK / 2;
   localparam int SEEK_HALF            = (SEEK_HALF_RAW == 0) ? 1 : SEEK_HALF_RAW;
   localparam int DIV_W                = 13;
   localparam int DIV_CNT_W            = $clog2(DIV_W);
   localparam int CRC_STEPS            = 32;
   localparam int STEP_CNT_W           = 5;

   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [3:0] M_OFF      = 4'd0;
   localparam logic [3:0] M_LOAD     = 4'd1;
   localparam logic [3:0] M_SPINUP   = 4'd2;
   localparam logic [3:0] M_BRUSH    = 4'd3;
   localparam logic [3:0] M_HEADS    = 4'd4;
   localparam logic [3:0] M_SEEK     = 4'd5;
   localparam logic [3:0] M_LOCK     = 4'd6;
   localparam logic [3:0] M_UNLOAD   = 4'd7;
   localparam logic [3:0] M_SPINDOWN = 4'd8;

   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_SEEK       = 3'd1;
   localparam logic [2:0] OP_READ_HDR   = 3'd2;
   localparam logic [2:0] OP_READ_DATA  = 3'd3;
   localparam logic [2:0] OP_WRITE_DATA = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;

   localparam logic [2:0] CSR_DRIVE_KIND   = 3'd0;
   localparam logic [2:0] CSR_FULL_RPM     = 3'd1;
   localparam logic [2:0] CSR_SPINUP_SEC   = 3'd2;
   localparam logic [2:0] CSR_SPEED_FACTOR = 3'd3;
   localparam logic [2:0] CSR_HEAD_MOVE    = 3'd4;

   typedef struct packed {
      logic [2:0] operation;
      logic       power_on;
      logic       run_pressed;
      logic       cover_is_open;
      logic       write_locked;
      logic       medium_ok;
      logic       clock_missing;
      logic [8:0] target_cylinder;
      logic       target_head;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [3:0]  drive_state;
      logic        ready_line;
      logic        error_line;
      logic        write_gate_error;
      logic [8:0]  cylinder_now;
      logic [1:0]  head_now;
      logic [15:0] header_word;
      logic [15:0] header_crc;
      logic [15:0] block_index;
      logic [9:0]  wait_ms;
      logic [11:0] rpm_now;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic crc_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_crc;
   } stat_type;

   function automatic logic [6:0] seg_next(input logic [6:0] s);
      logic [7:0] n;
      n = {1'b0, s} + 8'd1;
      seg_next = (n >= 8'(SEG_COUNT)) ? 7'd0 : n[6:0];
   endfunction

endpackage

// ===== rtl/cddm_ctrl.sv =====
module cddm_ctrl
   import cddm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_CRC  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(DIV_W - 1)) begin
               cnt_in   = '0;
               state_in = stat.need_crc ? S_CRC : S_DONE;
            end
         end
         S_CRC: begin
            cmd.crc_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(CRC_STEPS - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/cddm_dp.sv =====
module cddm_dp
   import cddm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  req_type     req,
   input  logic        cfg_we,
   input  logic [2:0]  cfg_index,
   input  logic [11:0] cfg_wdata,
   output rsp_type     rsp,
   output logic        rsp_valid
);

   logic [1:0]  kind_ff;
   logic [11:0] full_ff;
   logic [7:0]  spin_sec_ff;
   logic [4:0]  factor_ff;
   logic [9:0]  hmove_ff;

   logic [3:0]  mode_ff, mode_in;
   logic [8:0]  cyl_ff, cyl_in;
   logic [1:0]  head_ff, head_in;
   logic [8:0]  dcyl_ff, dcyl_in;
   logic        dhead_ff, dhead_in;
   logic [11:0] rpm_ff, rpm_in;
   logic [6:0]  seg_ff, seg_in;
   logic        fault_ff, fault_in, vol_ff, vol_in, wge_ff, wge_in;
   logic        rdy_ff, rdy_in, err_ff, err_in;

   req_type     item_ff;
   logic [DIV_W-1:0] rem_ff, quo_ff, dvs_ff;
   logic [15:0] crc_ff, hw_ff;
   logic [31:0] crc_data_ff;
   logic [DIV_W:0] shifted;
   logic        div_bit, fb;

   logic [9:0]  inc;
   logic [8:0]  cyl_gap;
   logic [8:0]  spin_div;
   logic [6:0]  seg_hdr;
   logic [15:0] hw_now;
   rsp_type     out;

   assign inc = (kind_ff == 2'd1) ? 10'(SEEK_HALF) : 10'(SEEK_TRACKS_PER_TICK);
   assign cyl_gap = (dcyl_ff > cyl_ff) ? (dcyl_ff - cyl_ff) : (cyl_ff - dcyl_ff);
   assign spin_div = (spin_sec_ff == 8'd0) ? 9'd1 : {1'b0, spin_sec_ff};
   assign seg_hdr = seg_ff[0] ? seg_next(seg_ff) : seg_ff;
   assign hw_now = {cyl_ff, head_ff[0], seg_hdr[6:1]};
   assign stat.need_crc = (item_ff.operation == OP_READ_HDR) && (mode_ff == M_LOCK);

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign div_bit = (shifted >= {1'b0, dvs_ff});
   assign fb = crc_ff[0] ^ crc_data_ff[0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff     <= req;
         rem_ff      <= '0;
         crc_ff      <= '0;
         hw_ff       <= hw_now;
         crc_data_ff <= {16'h0000, hw_now};
         if (mode_ff == M_SEEK) begin
            quo_ff <= DIV_W'(cyl_gap) * DIV_W'(10);
            dvs_ff <= DIV_W'(inc);
         end else begin
            quo_ff <= DIV_W'(full_ff);
            dvs_ff <= DIV_W'(spin_div) * DIV_W'(10);
         end
      end
      if (cmd.div_step) begin
         rem_ff <= div_bit ? DIV_W'(shifted - {1'b0, dvs_ff}) : shifted[DIV_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], div_bit};
      end
      if (cmd.crc_step) begin
         crc_ff      <= {1'b0, crc_ff[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
         crc_data_ff <= {1'b0, crc_data_ff[31:1]};
      end
   end

   always_comb begin
      logic        run, stop;
      logic [3:0]  m;
      logic [16:0] step;
      logic [17:0] t;
      logic [10:0] reach;
      logic [6:0]  s1;
      logic [15:0] blk;
      logic        lock;

      mode_in  = mode_ff;   cyl_in  = cyl_ff;   head_in = head_ff;
      dcyl_in  = dcyl_ff;   dhead_in = dhead_ff; rpm_in = rpm_ff;
      seg_in   = seg_ff;    fault_in = fault_ff; vol_in = vol_ff;
      wge_in   = wge_ff;    rdy_in   = rdy_ff;
      err_in   = err_ff | vol_ff | wge_ff;
      out      = '0;
      run      = item_ff.run_pressed;
      step     = 17'(quo_ff[11:0]) * 17'(factor_ff);
      t        = 18'(rpm_ff) + 18'(step);
      reach    = 11'(cyl_ff) + 11'(inc);
      lock     = (mode_ff == M_LOCK);
      m        = item_ff.power_on ? mode_ff : M_OFF;
      s1       = '0;
      blk      = '0;
      stop     = 1'b0;

      case (item_ff.operation)
         OP_TICK: begin
            out.accepted = 1'b1;
            if (item_ff.clock_missing) fault_in = 1'b1;
            stop    = !run || fault_in;
            mode_in = m;
            unique case (m)
               M_LOAD: begin
                  rdy_in = 1'b0;
                  if (run && !item_ff.cover_is_open) begin
                     if (item_ff.medium_ok) begin
                        fault_in = 1'b0;
                        mode_in  = M_SPINUP;
                     end else begin
                        fault_in    = 1'b1;
                        out.wait_ms = 10'd100;
                     end
                  end else begin
                     fault_in    = 1'b0;
                     out.wait_ms = 10'd100;
                  end
               end
               M_SPINUP: begin
                  vol_in = 1'b1;
                  rdy_in = 1'b0;
                  if (stop) mode_in = M_SPINDOWN;
                  else if (t > 18'(full_ff)) begin
                     rpm_in  = full_ff;
                     cyl_in  = '0;
                     mode_in = M_BRUSH;
                  end else begin
                     rpm_in      = t[11:0];
                     out.wait_ms = 10'd100;
                  end
               end
               M_BRUSH: begin
                  rdy_in      = 1'b0;
                  mode_in     = M_HEADS;
                  out.wait_ms = 10'd100;
               end
               M_HEADS: begin
                  rdy_in      = 1'b0;
                  cyl_in      = '0;
                  dcyl_in     = '0;
                  dhead_in    = 1'b0;
                  head_in     = 2'd3;
                  mode_in     = M_SEEK;
                  seg_in      = 7'(SEG_START);
                  out.wait_ms = hmove_ff;
               end
               M_SEEK: begin
                  rdy_in = 1'b0;
                  if (stop) mode_in = M_SPINDOWN;
                  else if ({1'b0, dhead_ff} != head_ff) begin
                     head_in     = {1'b0, dhead_ff};
                     out.wait_ms = 10'd5;
                  end else if ((dcyl_ff > cyl_ff) ? (reach >= 11'(dcyl_ff))
                                                  : (10'(cyl_gap) <= inc)) begin
                     out.wait_ms = quo_ff[9:0];
                     cyl_in      = dcyl_ff;
                     mode_in     = M_LOCK;
                  end else begin
                     cyl_in      = (dcyl_ff > cyl_ff) ? reach[8:0] : (cyl_ff - inc[8:0]);
                     out.wait_ms = 10'd10;
                  end
               end
               M_LOCK: begin
                  if (stop) mode_in = M_UNLOAD;
                  else begin
                     rdy_in      = 1'b1;
                     out.wait_ms = 10'd1;
                  end
               end
               M_UNLOAD: begin
                  rdy_in      = 1'b0;
                  mode_in     = M_SPINDOWN;
                  out.wait_ms = hmove_ff;
               end
               M_SPINDOWN: begin
                  rdy_in = 1'b0;
                  if (17'(rpm_ff) <= step) begin
                     rpm_in  = '0;
                     mode_in = M_LOAD;
                  end else begin
                     rpm_in      = rpm_ff - step[11:0];
                     out.wait_ms = 10'd100;
                  end
               end
               default: begin
                  mode_in     = item_ff.power_on ? M_LOAD : M_OFF;
                  vol_in      = 1'b1;
                  rdy_in      = 1'b0;
                  err_in      = 1'b1;
                  fault_in    = 1'b0;
                  out.wait_ms = 10'd100;
               end
            endcase
         end
         OP_SEEK: begin
            if (lock) begin
               dcyl_in  = (kind_ff == 2'd1) ? {1'b0, item_ff.target_cylinder[7:0]}
                                            : item_ff.target_cylinder;
               dhead_in = item_ff.target_head;
               head_in  = 2'd3;
               rdy_in   = 1'b0;
               mode_in  = M_SEEK;
               out.accepted = 1'b1;
            end
         end
         OP_READ_HDR: begin
            if (lock) begin
               out.header_word = hw_ff;
               out.header_crc  = crc_ff;
               seg_in          = seg_next(seg_hdr);
               out.accepted    = 1'b1;
            end
         end
         OP_READ_DATA, OP_WRITE_DATA: begin
            if (lock) begin
               out.accepted = 1'b1;
               if (item_ff.operation == OP_WRITE_DATA
                   && (item_ff.write_locked || !rdy_ff)) begin
                  wge_in = 1'b1;
               end else begin
                  if (item_ff.operation == OP_WRITE_DATA) wge_in = 1'b0;
                  s1  = seg_ff[0] ? seg_ff : seg_next(seg_ff);
                  blk = ({6'd0, cyl_ff, 1'b0} + 16'(head_ff[0])) * 16'(SECTORS_PER_TRACK)
                        + 16'(s1[6:1]);
                  out.block_index = blk;
                  seg_in = seg_next(s1);
               end
            end
         end
         OP_CLEAR: begin
            wge_in = 1'b0;
            vol_in = 1'b0;
            err_in = 1'b0;
            out.accepted = 1'b1;
         end
         default: ;
      endcase

      err_in               = err_in | vol_in | wge_in;
      out.drive_state      = mode_in;
      out.ready_line       = rdy_in;
      out.error_line       = err_in;
      out.write_gate_error = wge_in;
      out.cylinder_now     = cyl_in;
      out.head_now         = head_in;
      out.rpm_now          = rpm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= 2'd2;
         full_ff     <= 12'd2400;
         spin_sec_ff <= 8'd8;
         factor_ff   <= 5'd1;
         hmove_ff    <= 10'd100;
         mode_ff     <= M_OFF;
         cyl_ff      <= '0;
         head_ff     <= '0;
         dcyl_ff     <= '0;
         dhead_ff    <= 1'b0;
         rpm_ff      <= '0;
         seg_ff      <= 7'(SEG_START);
         fault_ff    <= 1'b0;
         vol_ff      <= 1'b1;
         wge_ff      <= 1'b0;
         rdy_ff      <= 1'b0;
         err_ff      <= 1'b1;
         rsp_valid   <= 1'b0;
      end else begin
         rsp_valid <= cmd.commit;
         if (cfg_we) begin
            unique case (cfg_index)
               CSR_DRIVE_KIND:   kind_ff     <= cfg_wdata[1:0];
               CSR_FULL_RPM:     full_ff     <= cfg_wdata;
               CSR_SPINUP_SEC:   spin_sec_ff <= cfg_wdata[7:0];
               CSR_SPEED_FACTOR: factor_ff   <= cfg_wdata[4:0];
               CSR_HEAD_MOVE:    hmove_ff    <= cfg_wdata[9:0];
               default: ;
            endcase
         end
         if (cmd.commit) begin
            mode_ff  <= mode_in;  cyl_ff   <= cyl_in;   head_ff <= head_in;
            dcyl_ff  <= dcyl_in;  dhead_ff <= dhead_in; rpm_ff  <= rpm_in;
            seg_ff   <= seg_in;   fault_ff <= fault_in; vol_ff  <= vol_in;
            wge_ff   <= wge_in;   rdy_ff   <= rdy_in;   err_ff  <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp <= out;
   end

endmodule

// ===== rtl/cartridge_disk_drive_model_unit.sv =====
// Channel | Ports                                   | Handshake
// request | start, busy, req_data                   | taken when start and !busy
// result  | rsp_valid, rsp_data                     | one-cycle strobe
// config  | csr_valid, csr_ready, csr_index, csr_wdata | write when valid and ready
//
// An item runs a load, 13 divider steps and a commit; a header read while locked
// adds 32 steps of bit-serial CRC. The restoring divider is shared by the seek and
// spin-speed arithmetic. The word appears in the cycle after commit, as busy drops.
// Reset is synchronous; the receiver cannot stall, and config is always ready.
module cartridge_disk_drive_model_unit
   import cddm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   cddm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   cddm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req       (req_data),
      .cfg_we    (csr_valid & csr_ready),
      .cfg_index (csr_index),
      .cfg_wdata (csr_wdata),
      .rsp       (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule
